### design/wftq_pkg.sv
// Shared constants, codes and width helpers for the windowed tri-state fault qualifier.
package wftq_pkg;

    localparam int unsigned CHANNELS_DEFAULT = 6;
    localparam int unsigned WINDOW_DEFAULT   = 16;

    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned STATE_IN_W = 2;
    localparam int unsigned THRESH_W   = 5;
    localparam int unsigned SUM_OUT_W  = 6;
    localparam int unsigned MAG_OUT_W  = 5;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;

    // two's complement -2, folded onto the low state
    localparam logic [STATE_IN_W-1:0] STATE_LOW_ALT = 2'b10;
    localparam logic [STATE_IN_W-1:0] STATE_LOW     = 2'b11;

    typedef enum logic [0:0] {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAULT_ENABLE    = 1'b0,
        REG_COUNT_THRESHOLD = 1'b1
    } cfg_reg_t;

    function automatic int unsigned idx_width(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int unsigned slot_width(input int unsigned window);
        return idx_width(window);
    endfunction

    function automatic int unsigned mag_width(input int unsigned window);
        return $clog2(window + 1);
    endfunction

    function automatic int unsigned sum_width(input int unsigned window);
        return $clog2(window + 1) + 1;
    endfunction

    // packed channel state: {wrapped, slot, sum, mag}
    function automatic int unsigned state_width(input int unsigned window);
        return 1 + slot_width(window) + sum_width(window) + mag_width(window);
    endfunction

endpackage

### design/wftq_if.sv
// Valid/ready channel interfaces for samples and qualified results.
interface wftq_sample_if
    import wftq_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [CHAN_W-1:0]            channel;
    logic signed [STATE_IN_W-1:0] pressure_state;

    modport source (output valid, output kind, output channel, output pressure_state,
                    input ready);
    modport sink   (input valid, input kind, input channel, input pressure_state,
                    output ready);
endinterface

interface wftq_result_if
    import wftq_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [CHAN_W-1:0]           channel_out;
    logic                        low_fault;
    logic                        high_fault;
    logic                        oscillation_fault;
    logic signed [SUM_OUT_W-1:0] window_sum;
    logic [MAG_OUT_W-1:0]        window_abs_sum;

    modport source (output valid, output channel_out, output low_fault, output high_fault,
                    output oscillation_fault, output window_sum, output window_abs_sum,
                    input ready);
    modport sink   (input valid, input channel_out, input low_fault, input high_fault,
                    input oscillation_fault, input window_sum, input window_abs_sum,
                    output ready);
endinterface

### design/wftq_hist_store.sv
// Window history RAM: one write port, one registered read port.
module wftq_hist_store
    import wftq_pkg::*;
#(
    parameter int unsigned DEPTH = CHANNELS_DEFAULT * WINDOW_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [idx_width(DEPTH)-1:0] wr_addr,
    input  logic [STATE_IN_W-1:0]       wr_data,
    input  logic                        rd_en,
    input  logic [idx_width(DEPTH)-1:0] rd_addr,
    output logic [STATE_IN_W-1:0]       rd_data
);

    logic [STATE_IN_W-1:0] mem [DEPTH];
    logic [STATE_IN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/wftq_chan_store.sv
// Per-channel running state RAM with live bits that reset or a clear zeroes at once.
module wftq_chan_store
    import wftq_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEFAULT,
    parameter int unsigned STATE_W  = state_width(WINDOW_DEFAULT)
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [idx_width(CHANNELS)-1:0] rd_idx,
    output logic [STATE_W-1:0]             rd_data,
    input  logic [idx_width(CHANNELS)-1:0] look_idx,
    output logic                           look_live,
    input  logic                           wr_en,
    input  logic [idx_width(CHANNELS)-1:0] wr_idx,
    input  logic [STATE_W-1:0]             wr_data,
    input  logic                           clear
);

    logic [STATE_W-1:0]  mem [CHANNELS];
    logic [STATE_W-1:0]  rd_data_reg;
    logic [CHANNELS-1:0] live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            priority if (clear)
            begin
                live_reg <= '0;
            end
            else if (wr_en)
            begin
                live_reg[wr_idx] <= 1'b1;
            end
            else
            begin
                live_reg <= live_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data   = rd_data_reg;
    assign look_live = live_reg[look_idx];

endmodule

### design/wftq_update.sv
// Window update: running sums, slot advance, fault compare and output saturation.
module wftq_update
    import wftq_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
)
(
    input  logic [state_width(WINDOW)-1:0] state_in,
    input  logic signed [STATE_IN_W-1:0]   old_entry,
    input  logic signed [STATE_IN_W-1:0]   new_entry,
    input  logic                           fault_enable,
    input  logic [THRESH_W-1:0]            threshold,
    output logic [state_width(WINDOW)-1:0] state_out,
    output logic                           low_fault,
    output logic                           high_fault,
    output logic                           oscillation_fault,
    output logic signed [SUM_OUT_W-1:0]    sum_out,
    output logic [MAG_OUT_W-1:0]           mag_out
);

    localparam int unsigned SLOT_W = slot_width(WINDOW);
    localparam int unsigned SUM_W  = sum_width(WINDOW);
    localparam int unsigned MAG_W  = mag_width(WINDOW);
    localparam int unsigned CMP_W  = ((SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W) + 1;
    localparam int SUM_MAX = (2 ** (SUM_OUT_W - 1)) - 1;
    localparam int SUM_MIN = -(2 ** (SUM_OUT_W - 1));
    localparam int MAG_MAX = (2 ** MAG_OUT_W) - 1;

    typedef struct packed {
        logic                    wrapped;
        logic [SLOT_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
        logic [MAG_W-1:0]        mag;
    } chan_state_t;

    chan_state_t             cur;
    chan_state_t             nxt;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] mag_x;
    logic signed [CMP_W-1:0] th_x;

    assign cur       = state_in;
    assign state_out = nxt;

    always_comb
    begin
        nxt     = cur;
        nxt.sum = cur.sum + SUM_W'(new_entry) - SUM_W'(old_entry);
        nxt.mag = cur.mag + MAG_W'(new_entry != '0) - MAG_W'(old_entry != '0);
        if (cur.slot == SLOT_W'(WINDOW - 1))
        begin
            nxt.slot    = '0;
            nxt.wrapped = 1'b1;
        end
        else
        begin
            nxt.slot = cur.slot + SLOT_W'(1);
        end
    end

    assign sum_x = CMP_W'(nxt.sum);
    assign mag_x = $signed(CMP_W'(nxt.mag));
    assign th_x  = $signed(CMP_W'(threshold));

    assign low_fault         = fault_enable && (-sum_x >= th_x);
    assign high_fault        = fault_enable && (sum_x >= th_x);
    assign oscillation_fault = fault_enable && (mag_x >= th_x);

    always_comb
    begin
        priority if (sum_x > CMP_W'(SUM_MAX))
        begin
            sum_out = SUM_OUT_W'(SUM_MAX);
        end
        else if (sum_x < CMP_W'(SUM_MIN))
        begin
            sum_out = SUM_OUT_W'(SUM_MIN);
        end
        else
        begin
            sum_out = SUM_OUT_W'(sum_x);
        end

        if (mag_x > CMP_W'(MAG_MAX))
        begin
            mag_out = MAG_OUT_W'(MAG_MAX);
        end
        else
        begin
            mag_out = MAG_OUT_W'(mag_x);
        end
    end

endmodule

### design/windowed_tristate_fault_qualifier.sv
// Top level: sliding-window tri-state pressure fault qualifier.
//
//   Channel   Dir  Handshake      Payload
//   sample    in   valid/ready    kind, channel, pressure_state
//   result    out  valid/ready    channel_out, low/high/oscillation_fault,
//                                 window_sum, window_abs_sum
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One item per cycle sustained; items pass stage 1, stage 2 and the output register.
// The rate is set by the per-channel read-modify-write of the state RAM, with
// forwarding from the update stage and from the previous write.
// Reset clears per-channel live bits at once; no clearing pass. A clear item
// resets all live bits at once the same way.
// The pipeline holds while the output register is full, not taken and the
// update stage is occupied; a bubble in the update stage lets the earlier stages move.
module windowed_tristate_fault_qualifier
    import wftq_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEFAULT,
    parameter int unsigned WINDOW   = WINDOW_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wftq_sample_if.sink           sample,
    wftq_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned IDX_W   = idx_width(CHANNELS);
    localparam int unsigned EXT_W   = ((IDX_W > CHAN_W) ? IDX_W : CHAN_W) + 1;
    localparam int unsigned SLOT_W  = slot_width(WINDOW);
    localparam int unsigned SUM_W   = sum_width(WINDOW);
    localparam int unsigned MAG_W   = mag_width(WINDOW);
    localparam int unsigned STATE_W = state_width(WINDOW);
    localparam int unsigned DEPTH   = CHANNELS * WINDOW;
    localparam int unsigned HIST_AW = idx_width(DEPTH);

    typedef struct packed {
        logic                    wrapped;
        logic [SLOT_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
        logic [MAG_W-1:0]        mag;
    } chan_state_t;

    function automatic logic chan_in_range(input logic [CHAN_W-1:0] chan);
        return EXT_W'(chan) < EXT_W'(CHANNELS);
    endfunction

    function automatic logic [IDX_W-1:0] chan_index(input logic [CHAN_W-1:0] chan);
        logic [EXT_W-1:0] wide;
        wide = EXT_W'(chan);
        return wide[IDX_W-1:0];
    endfunction

    function automatic logic [HIST_AW-1:0] hist_addr(input logic [IDX_W-1:0]  idx,
                                                     input logic [SLOT_W-1:0] slot);
        return HIST_AW'(HIST_AW'(idx) * HIST_AW'(WINDOW)) + HIST_AW'(slot);
    endfunction

    // configuration
    logic                fault_enable_reg;
    logic [THRESH_W-1:0] count_threshold_reg;

    // stage 1: channel state read returns
    logic                  s1_valid_reg;
    logic                  s1_clear_reg;
    logic [CHAN_W-1:0]     s1_chan_reg;
    logic [STATE_IN_W-1:0] s1_st_reg;
    logic                  s1_in_range;
    logic [IDX_W-1:0]      s1_idx;
    chan_state_t           s1_state;
    logic                  s1_hfwd;

    // stage 2: history read returns, update and write back
    logic                  s2_valid_reg;
    logic                  s2_clear_reg;
    logic                  s2_live_reg;
    logic [CHAN_W-1:0]     s2_chan_reg;
    logic [IDX_W-1:0]      s2_idx_reg;
    logic [STATE_IN_W-1:0] s2_st_reg;
    chan_state_t           s2_state_reg;
    logic                  s2_hfwd_reg;
    logic [STATE_IN_W-1:0] s2_hfwd_data_reg;
    logic [STATE_IN_W-1:0] s2_old_entry;
    chan_state_t           s2_new_state;
    logic                  s2_write;
    logic                  s2_low;
    logic                  s2_high;
    logic                  s2_osc;
    logic signed [SUM_OUT_W-1:0] s2_sum;
    logic [MAG_OUT_W-1:0]  s2_mag;

    // write that landed at the edge where the stage 1 read was taken
    logic                  wb_valid_reg;
    logic [IDX_W-1:0]      wb_idx_reg;
    chan_state_t           wb_state_reg;

    // output register
    logic                        out_valid_reg;
    logic [CHAN_W-1:0]           out_chan_reg;
    logic                        out_low_reg;
    logic                        out_high_reg;
    logic                        out_osc_reg;
    logic signed [SUM_OUT_W-1:0] out_sum_reg;
    logic [MAG_OUT_W-1:0]        out_mag_reg;

    logic                  advance;
    logic [STATE_IN_W-1:0] s0_st;
    logic [STATE_W-1:0]    chan_rd;
    logic                  chan_live;
    logic [STATE_IN_W-1:0] hist_rd;

    assign advance      = !out_valid_reg || result.ready || !s2_valid_reg;
    assign sample.ready = advance;

    assign s0_st = (sample.pressure_state == STATE_LOW_ALT) ? STATE_LOW
                                                             : sample.pressure_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_enable_reg    <= 1'b0;
            count_threshold_reg <= THRESH_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FAULT_ENABLE:    fault_enable_reg    <= cfg_data[0];
                REG_COUNT_THRESHOLD: count_threshold_reg <= cfg_data[THRESH_W-1:0];
            endcase
        end
    end

    wftq_chan_store #(
        .CHANNELS (CHANNELS),
        .STATE_W  (STATE_W)
    ) u_chan_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (advance),
        .rd_idx    (chan_index(sample.channel)),
        .rd_data   (chan_rd),
        .look_idx  (s1_idx),
        .look_live (chan_live),
        .wr_en     (s2_write),
        .wr_idx    (s2_idx_reg),
        .wr_data   (s2_new_state),
        .clear     (advance && s2_valid_reg && s2_clear_reg)
    );

    assign s1_in_range = chan_in_range(s1_chan_reg);
    assign s1_idx      = chan_index(s1_chan_reg);

    always_comb
    begin
        priority if (s2_valid_reg && s2_clear_reg)
        begin
            s1_state = '0;
        end
        else if (s2_valid_reg && s2_live_reg && (s2_idx_reg == s1_idx))
        begin
            s1_state = s2_new_state;
        end
        else if (wb_valid_reg && (wb_idx_reg == s1_idx))
        begin
            s1_state = wb_state_reg;
        end
        else if (chan_live)
        begin
            s1_state = chan_rd;
        end
        else
        begin
            s1_state = '0;
        end
    end

    // same history entry written by stage 2 at the read edge (single-slot window)
    assign s1_hfwd = s2_valid_reg && s2_live_reg && (s2_idx_reg == s1_idx)
                     && (s2_state_reg.slot == s1_state.slot);

    wftq_hist_store #(
        .DEPTH (DEPTH)
    ) u_hist_store (
        .clk     (clk),
        .wr_en   (s2_write),
        .wr_addr (hist_addr(s2_idx_reg, s2_state_reg.slot)),
        .wr_data (s2_st_reg),
        .rd_en   (advance),
        .rd_addr (hist_addr(s1_idx, s1_state.slot)),
        .rd_data (hist_rd)
    );

    assign s2_write     = advance && s2_valid_reg && s2_live_reg;
    assign s2_old_entry = !s2_state_reg.wrapped ? '0
                        : (s2_hfwd_reg ? s2_hfwd_data_reg : hist_rd);

    wftq_update #(
        .WINDOW (WINDOW)
    ) u_update (
        .state_in          (s2_state_reg),
        .old_entry         (s2_old_entry),
        .new_entry         (s2_st_reg),
        .fault_enable      (fault_enable_reg),
        .threshold         (count_threshold_reg),
        .state_out         (s2_new_state),
        .low_fault         (s2_low),
        .high_fault        (s2_high),
        .oscillation_fault (s2_osc),
        .sum_out           (s2_sum),
        .mag_out           (s2_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= sample.valid;
                s2_valid_reg <= s1_valid_reg;
                wb_valid_reg <= s2_write;
            end
            priority if (advance && s2_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_clear_reg     <= (sample.kind == KIND_CLEAR);
            s1_chan_reg      <= sample.channel;
            s1_st_reg        <= s0_st;

            s2_clear_reg     <= s1_clear_reg;
            s2_live_reg      <= !s1_clear_reg && s1_in_range;
            s2_chan_reg      <= s1_chan_reg;
            s2_idx_reg       <= s1_idx;
            s2_st_reg        <= s1_st_reg;
            s2_state_reg     <= s1_state;
            s2_hfwd_reg      <= s1_hfwd;
            s2_hfwd_data_reg <= s2_st_reg;

            wb_idx_reg       <= s2_idx_reg;
            wb_state_reg     <= s2_new_state;
        end
        if (advance && s2_valid_reg)
        begin
            out_chan_reg <= s2_chan_reg;
            if (s2_live_reg)
            begin
                out_low_reg  <= s2_low;
                out_high_reg <= s2_high;
                out_osc_reg  <= s2_osc;
                out_sum_reg  <= s2_sum;
                out_mag_reg  <= s2_mag;
            end
            else
            begin
                out_low_reg  <= 1'b0;
                out_high_reg <= 1'b0;
                out_osc_reg  <= 1'b0;
                out_sum_reg  <= '0;
                out_mag_reg  <= '0;
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.channel_out       = out_chan_reg;
    assign result.low_fault         = out_low_reg;
    assign result.high_fault        = out_high_reg;
    assign result.oscillation_fault = out_osc_reg;
    assign result.window_sum        = out_sum_reg;
    assign result.window_abs_sum    = out_mag_reg;

endmodule

### design/wftq_checker.sv
// Port-level checks on the result channel, bound to the top level.
module wftq_checker
    import wftq_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [CHAN_W-1:0]           channel_out,
    input logic                        low_fault,
    input logic                        high_fault,
    input logic                        oscillation_fault,
    input logic signed [SUM_OUT_W-1:0] window_sum,
    input logic [MAG_OUT_W-1:0]        window_abs_sum
);

    logic signed [SUM_OUT_W:0] sum_x;
    logic signed [SUM_OUT_W:0] mag_x;

    assign sum_x = (SUM_OUT_W + 1)'(window_sum);
    assign mag_x = $signed((SUM_OUT_W + 1)'(window_abs_sum));

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
        $stable({channel_out, low_fault, high_fault, oscillation_fault,
                 window_sum, window_abs_sum}))
        else $error("result payload changed while stalled");

    a_fault_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!low_fault || (window_sum <= 0)) && (!high_fault || (window_sum >= 0)))
        else $error("fault direction disagrees with window sum");

    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (window_abs_sum == {MAG_OUT_W{1'b1}})
                         || ((mag_x >= sum_x) && (mag_x >= -sum_x)))
        else $error("nonzero count below magnitude of window sum");

    a_osc_cover: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (low_fault || high_fault) |-> oscillation_fault)
        else $error("level fault without oscillation fault");

endmodule

bind windowed_tristate_fault_qualifier wftq_checker u_wftq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .channel_out       (result.channel_out),
    .low_fault         (result.low_fault),
    .high_fault        (result.high_fault),
    .oscillation_fault (result.oscillation_fault),
    .window_sum        (result.window_sum),
    .window_abs_sum    (result.window_abs_sum)
);
